[src/lags_pkg.sv]
// ----------------------------------------------------------------------------
// Life grid step package
// Field widths, operation codes, controller states and the command and
// status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package lags_pkg;

   localparam int MODE_W  = 3;
   localparam int COORD_W = 6;
   localparam int POP_W   = 13;
   localparam int GEN_W   = 32;

   localparam logic [POP_W-1:0] POP_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_SET_DEAD  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET_ALIVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STEP      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

   typedef enum logic [3:0] {
      ST_BOOT_CLR,
      ST_IDLE,
      ST_CLEAR,
      ST_WR_READ,
      ST_WR_WRITE,
      ST_RD_READ,
      ST_RD_CAPTURE,
      ST_STEP_INIT,
      ST_STEP_PRIME,
      ST_STEP_FETCH,
      ST_STEP_CELL,
      ST_STEP_ROWEND,
      ST_STEP_DONE,
      ST_RESULT
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic clr_start;
      logic clr_row;
      logic edit_rd;
      logic edit_wr;
      logic read_cap;
      logic step_init;
      logic step_prime;
      logic step_fetch;
      logic step_cell;
      logic step_rowend;
      logic step_done;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic row_last;
      logic col_last;
      logic rsp_blocked;
   } ctl_status_type;

endpackage

[src/lags_if.sv]
// ----------------------------------------------------------------------------
// Life grid step channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lags_req_if;
   import lags_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [COORD_W-1:0] cell_x;
   logic [COORD_W-1:0] cell_y;

   modport source (output valid, output mode, output cell_x, output cell_y, input ready);
   modport sink   (input valid, input mode, input cell_x, input cell_y, output ready);
endinterface

interface lags_rsp_if;
   import lags_pkg::*;

   logic             valid;
   logic             ready;
   logic             cell_alive;
   logic [POP_W-1:0] population;
   logic [GEN_W-1:0] generation;
   logic             stable;

   modport source (output valid, output cell_alive, output population,
                   output generation, output stable, input ready);
   modport sink   (input valid, input cell_alive, input population,
                   input generation, input stable, output ready);
endinterface

[src/lags_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lags_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[src/lags_ctrl.sv]
// ----------------------------------------------------------------------------
// Life grid step controller
// Sequences the clearing pass, cell edits, reads and the generation sweep.
// ----------------------------------------------------------------------------
module lags_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [lags_pkg::MODE_W-1:0]    req_mode,
   output logic                           req_ready,
   input  lags_pkg::ctl_status_type       status,
   output lags_pkg::ctl_cmd_type          cmd
);
   import lags_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_BOOT_CLR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode) inside
                  MODE_SET_DEAD, MODE_SET_ALIVE: state_in = ST_WR_READ;
                  MODE_CLEAR:                    state_in = ST_CLEAR;
                  MODE_STEP:                     state_in = ST_STEP_INIT;
                  MODE_READ:                     state_in = ST_RD_READ;
                  default:                       state_in = ST_RESULT;
               endcase
            end
         end
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_RESULT;
         end
         ST_WR_READ:     state_in = ST_WR_WRITE;
         ST_WR_WRITE:    state_in = ST_RESULT;
         ST_RD_READ:     state_in = ST_RD_CAPTURE;
         ST_RD_CAPTURE:  state_in = ST_RESULT;
         ST_STEP_INIT:   state_in = ST_STEP_PRIME;
         ST_STEP_PRIME:  state_in = ST_STEP_FETCH;
         ST_STEP_FETCH:  state_in = ST_STEP_CELL;
         ST_STEP_CELL: begin
            if (status.col_last) state_in = ST_STEP_ROWEND;
         end
         ST_STEP_ROWEND: begin
            state_in = status.row_last ? ST_STEP_DONE : ST_STEP_FETCH;
         end
         ST_STEP_DONE:   state_in = ST_RESULT;
         ST_RESULT: begin
            if (!status.rsp_blocked) state_in = ST_IDLE;
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_BOOT_CLR:    cmd.clr_row = 1'b1;
         ST_IDLE: begin
            cmd.capture   = accept;
            cmd.clr_start = accept && (req_mode == MODE_CLEAR);
         end
         ST_CLEAR:       cmd.clr_row     = 1'b1;
         ST_WR_READ:     cmd.edit_rd     = 1'b1;
         ST_WR_WRITE:    cmd.edit_wr     = 1'b1;
         ST_RD_READ:     cmd.edit_rd     = 1'b1;
         ST_RD_CAPTURE:  cmd.read_cap    = 1'b1;
         ST_STEP_INIT:   cmd.step_init   = 1'b1;
         ST_STEP_PRIME:  cmd.step_prime  = 1'b1;
         ST_STEP_FETCH:  cmd.step_fetch  = 1'b1;
         ST_STEP_CELL:   cmd.step_cell   = 1'b1;
         ST_STEP_ROWEND: cmd.step_rowend = 1'b1;
         ST_STEP_DONE:   cmd.step_done   = 1'b1;
         ST_RESULT:      cmd.emit        = !status.rsp_blocked;
         default:        cmd = '0;
      endcase
   end

endmodule

[src/lags_datapath.sv]
// ----------------------------------------------------------------------------
// Life grid step datapath
// Double-banked row memory, three-row window with a one-cell neighbor unit,
// counters and the response register.
// ----------------------------------------------------------------------------
module lags_datapath #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lags_pkg::MODE_W-1:0]    req_mode,
   input  logic [lags_pkg::COORD_W-1:0]   req_cell_x,
   input  logic [lags_pkg::COORD_W-1:0]   req_cell_y,
   input  lags_pkg::ctl_cmd_type          cmd,
   output lags_pkg::ctl_status_type       status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_cell_alive,
   output logic [lags_pkg::POP_W-1:0]     rsp_population,
   output logic [lags_pkg::GEN_W-1:0]     rsp_generation,
   output logic                           rsp_stable
);
   import lags_pkg::*;

   localparam int COL_W     = $clog2(GRID_WIDTH);
   localparam int ROW_W     = $clog2(GRID_HEIGHT);
   localparam int ADDR_W    = ROW_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_WIDTH - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_HEIGHT - 1);

   // Captured transaction.
   logic [MODE_W-1:0]  mode_ff;
   logic [COORD_W-1:0] cap_x_ff;
   logic [COORD_W-1:0] cap_y_ff;

   // Architectural state.
   logic             bank_ff;
   logic [GEN_W-1:0] gen_ff;
   logic [POP_W-1:0] pop_ff;
   logic             stable_ff;
   logic             alive_ff;

   // Sweep state.
   logic [ROW_W-1:0]      clr_cnt_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [COL_W-1:0]      col_ff;
   logic [GRID_WIDTH-1:0] prev_ff;
   logic [GRID_WIDTH-1:0] cur_ff;
   logic [GRID_WIDTH-1:0] nxt_ff;
   logic [GRID_WIDTH-1:0] new_ff;
   logic [2:0]            left_ff;
   logic [POP_W-1:0]      pop_acc_ff;
   logic                  changed_ff;

   // Response register.
   logic             rsp_valid_ff;
   logic             rsp_alive_ff;
   logic [POP_W-1:0] rsp_pop_ff;
   logic [GEN_W-1:0] rsp_gen_ff;
   logic             rsp_stable_ff;

   // Memory ports.
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [GRID_WIDTH-1:0] ram_wdata;
   logic                  ram_re;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [GRID_WIDTH-1:0] ram_rdata;

   logic                  in_grid;
   logic [ROW_W-1:0]      cap_row;
   logic [GRID_WIDTH-1:0] edit_row;
   logic                  edit_bit;
   logic                  right_ok;
   logic [3:0]            nbr_cnt;
   logic                  cell_now;
   logic                  cell_in;

   lags_ram #(
      .WIDTH (GRID_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign in_grid = (32'(cap_x_ff) < GRID_WIDTH) && (32'(cap_y_ff) < GRID_HEIGHT);
   assign cap_row = ROW_W'(cap_y_ff);

   // Edited row and the addressed bit, built without indexing past the row.
   always_comb begin
      edit_row = ram_rdata;
      edit_bit = 1'b0;
      for (int i = 0; i < GRID_WIDTH; i++) begin
         if (in_grid && (int'(cap_x_ff) == i)) begin
            edit_row[i] = (mode_ff == MODE_SET_ALIVE);
            edit_bit    = ram_rdata[i];
         end
      end
   end

   // One cell of the window: left column is held, center is bit 0 of the
   // rotating rows and right is bit 1 unless this is the last column.
   assign right_ok = (col_ff != LAST_COL);
   assign cell_now = cur_ff[0];
   assign nbr_cnt  = 4'(left_ff[0]) + 4'(left_ff[1]) + 4'(left_ff[2])
                   + 4'(prev_ff[0]) + 4'(nxt_ff[0])
                   + 4'(prev_ff[1] & right_ok) + 4'(cur_ff[1] & right_ok)
                   + 4'(nxt_ff[1] & right_ok);
   assign cell_in  = (nbr_cnt == 4'd3) || (cell_now && (nbr_cnt == 4'd2));

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {bank_ff, clr_cnt_ff};
      ram_wdata = '0;
      if (cmd.edit_wr) begin
         ram_we    = in_grid;
         ram_waddr = {bank_ff, cap_row};
         ram_wdata = edit_row;
      end else if (cmd.step_rowend) begin
         ram_we    = 1'b1;
         ram_waddr = {~bank_ff, row_ff};
         ram_wdata = new_ff;
      end else if (cmd.clr_row) begin
         ram_we    = 1'b1;
      end
   end

   always_comb begin
      ram_re    = cmd.edit_rd || cmd.step_init || cmd.step_prime || cmd.step_rowend;
      ram_raddr = {bank_ff, cap_row};
      if (cmd.step_init) begin
         ram_raddr = {bank_ff, ROW_W'(0)};
      end else if (cmd.step_prime) begin
         ram_raddr = {bank_ff, ROW_W'(1)};
      end else if (cmd.step_rowend) begin
         // Rows past the bottom edge are read but masked on arrival.
         ram_raddr = {bank_ff, ROW_W'(row_ff + ROW_W'(2))};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         cap_x_ff <= req_cell_x;
         cap_y_ff <= req_cell_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff    <= 1'b0;
         gen_ff     <= '0;
         pop_ff     <= '0;
         stable_ff  <= 1'b0;
         alive_ff   <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.capture) begin
            alive_ff <= 1'b0;
         end
         if (cmd.read_cap) begin
            alive_ff <= edit_bit;
         end
         if (cmd.clr_start) begin
            clr_cnt_ff <= '0;
            gen_ff     <= '0;
            pop_ff     <= '0;
            stable_ff  <= 1'b0;
         end else if (cmd.clr_row) begin
            clr_cnt_ff <= clr_cnt_ff + ROW_W'(1);
         end
         if (cmd.step_done) begin
            pop_ff    <= pop_acc_ff;
            stable_ff <= !changed_ff;
            if (changed_ff) begin
               bank_ff <= ~bank_ff;
               gen_ff  <= gen_ff + GEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_init) begin
         row_ff     <= '0;
         prev_ff    <= '0;
         pop_acc_ff <= '0;
         changed_ff <= 1'b0;
      end
      if (cmd.step_prime) begin
         cur_ff <= ram_rdata;
      end
      if (cmd.step_fetch) begin
         nxt_ff  <= (row_ff == LAST_ROW) ? '0 : ram_rdata;
         col_ff  <= '0;
         left_ff <= '0;
      end
      if (cmd.step_cell) begin
         // Rotating keeps each row intact after a full pass.
         prev_ff <= {prev_ff[0], prev_ff[GRID_WIDTH-1:1]};
         cur_ff  <= {cur_ff[0], cur_ff[GRID_WIDTH-1:1]};
         nxt_ff  <= {nxt_ff[0], nxt_ff[GRID_WIDTH-1:1]};
         new_ff  <= {cell_in, new_ff[GRID_WIDTH-1:1]};
         left_ff <= {nxt_ff[0], cur_ff[0], prev_ff[0]};
         col_ff  <= col_ff + COL_W'(1);
         if (cell_now && (pop_acc_ff != POP_MAX)) begin
            pop_acc_ff <= pop_acc_ff + POP_W'(1);
         end
         if (cell_in != cell_now) begin
            changed_ff <= 1'b1;
         end
      end
      if (cmd.step_rowend) begin
         prev_ff <= cur_ff;
         cur_ff  <= nxt_ff;
         row_ff  <= row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_alive_ff  <= alive_ff;
         rsp_pop_ff    <= pop_ff;
         rsp_gen_ff    <= gen_ff;
         rsp_stable_ff <= stable_ff;
      end
   end

   assign status.clr_last    = (clr_cnt_ff == LAST_ROW);
   assign status.row_last    = (row_ff == LAST_ROW);
   assign status.col_last    = (col_ff == LAST_COL);
   assign status.rsp_blocked = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_alive = rsp_alive_ff;
   assign rsp_population = rsp_pop_ff;
   assign rsp_generation = rsp_gen_ff;
   assign rsp_stable     = rsp_stable_ff;

   // A new result must never overwrite one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response overwritten while stalled");

   // The sweep writes the next generation only into the hidden bank.
   a_hidden_bank: assert property (@(posedge clock) disable iff (reset)
      cmd.step_rowend |-> (ram_waddr[ADDR_W-1] != bank_ff))
      else $error("step wrote into the visible bank");

   // A changing step advances the generation by exactly one and flips banks.
   a_gen_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.step_done && changed_ff) |=>
         (gen_ff == $past(gen_ff) + GEN_W'(1)) && (bank_ff != $past(bank_ff)))
      else $error("generation did not advance after a changing step");

endmodule

[src/life_automaton_grid_step.sv]
// ----------------------------------------------------------------------------
// Life automaton grid step
// Bounded B3/S23 grid with cell edit, read, clear and generation step.
// ----------------------------------------------------------------------------
// After reset the block clears the row memory and takes no request until that
// is done. A set or kill request reads the addressed row and writes it back, a
// read request reads the row and captures the addressed cell, an unused mode
// goes straight to its response, and a clear wipes the rows one by one. In a
// generation step the neighbor unit evaluates one cell per cycle while rows
// stream from a double-banked row memory, one row read and one row write for
// each row. Requests are handled one at a time; a finished response waits in
// an output register while the next request is accepted.
module life_automaton_grid_step #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input logic        clock,
   input logic        reset,
   lags_req_if.sink   req_chan,
   lags_rsp_if.source rsp_chan
);
   import lags_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;
   logic           req_ready;

   lags_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lags_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_chan.mode),
      .req_cell_x     (req_chan.cell_x),
      .req_cell_y     (req_chan.cell_y),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_cell_alive (rsp_chan.cell_alive),
      .rsp_population (rsp_chan.population),
      .rsp_generation (rsp_chan.generation),
      .rsp_stable     (rsp_chan.stable)
   );

   assign req_chan.ready = req_ready;

endmodule

[bench/life_automaton_grid_step_test.sv]
// ----------------------------------------------------------------------------
// Life automaton grid step testbench
// Sends cell edits, reads, clears, generation steps and unused modes to the
// grid, and checks every response against a B3/S23 predictor kept alongside.
// Both channels idle at random, with one quiet stretch, and the receiver holds
// off once for a long time so that the block backs up into its request side.
// ----------------------------------------------------------------------------
module life_automaton_grid_step_test;
   import lags_pkg::*;

   localparam int GRID_W       = 64;
   localparam int GRID_H       = 64;
   localparam int ITEM_TOTAL   = 140;
   localparam int IDLE_PERCENT = 37;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 20;
   localparam int QUIET_FIRST  = 60;
   localparam int QUIET_LAST   = 89;
   localparam int DRAIN_CYCLES = 4300;
   localparam int STALL_LIMIT  = 20000;
   localparam int REPORT_MAX   = 10;

   localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
   } life_request_type;

   typedef struct {
      logic             cell_alive;
      logic [POP_W-1:0] population;
      logic [GEN_W-1:0] generation;
      logic             stable;
   } life_status_type;

   logic clock;
   logic reset;

   lags_req_if req_bus ();
   lags_rsp_if rsp_bus ();

   life_automaton_grid_step #(
      .GRID_WIDTH  (GRID_W),
      .GRID_HEIGHT (GRID_H)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predicted grid state.
   bit               life_cells [GRID_H][GRID_W];
   bit               next_cells [GRID_H][GRID_W];
   logic [POP_W-1:0] life_population;
   logic [GEN_W-1:0] life_generation;
   logic             life_stable;

   life_request_type pending_requests[$];
   life_status_type  expected_status[$];
   life_request_type offered;
   life_request_type next_item;
   life_status_type  want;

   int sent_count;
   int accepted_count;
   int checked_count;
   int mismatch_count;
   int hold_left;
   bit hold_done;
   int quiet_cycles;
   int step_count;
   int stable_step_count;
   int read_count;
   int clear_count;
   int peak_population;

   function automatic bit cell_at(int x, int y);
      if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H)
         return 1'b0;
      return life_cells[y][x];
   endfunction

   function automatic void clear_cells();
      foreach (life_cells[y, x])
         life_cells[y][x] = 1'b0;
   endfunction

   function automatic void advance_generation();
      int live_total;
      int n;
      bit nxt;
      bit changed;
      live_total = 0;
      changed    = 1'b0;
      for (int y = 0; y < GRID_H; y++) begin
         for (int x = 0; x < GRID_W; x++) begin
            n = cell_at(x, y - 1) + cell_at(x + 1, y - 1) + cell_at(x + 1, y)
              + cell_at(x + 1, y + 1) + cell_at(x, y + 1) + cell_at(x - 1, y + 1)
              + cell_at(x - 1, y) + cell_at(x - 1, y - 1);
            if (life_cells[y][x]) begin
               live_total++;
               nxt = (n == 2 || n == 3);
            end else begin
               nxt = (n == 3);
            end
            if (nxt != life_cells[y][x])
               changed = 1'b1;
            next_cells[y][x] = nxt;
         end
      end
      // The population reflects the grid before this generation is applied.
      life_population = (live_total > POP_MAX) ? POP_MAX : live_total[POP_W-1:0];
      if (life_population > peak_population)
         peak_population = life_population;
      if (changed) begin
         life_cells      = next_cells;
         life_generation = life_generation + 1'b1;
         life_stable     = 1'b0;
      end else begin
         life_stable = 1'b1;
         stable_step_count++;
      end
   endfunction

   function automatic life_status_type apply_request(life_request_type r);
      life_status_type s;
      bit              in_grid;
      in_grid      = (r.cell_x < GRID_W) && (r.cell_y < GRID_H);
      s.cell_alive = 1'b0;
      case (r.mode)
         MODE_SET_DEAD, MODE_SET_ALIVE: begin
            if (in_grid)
               life_cells[r.cell_y][r.cell_x] = (r.mode == MODE_SET_ALIVE);
         end
         MODE_CLEAR: begin
            clear_cells();
            life_generation = '0;
            life_population = '0;
            life_stable     = 1'b0;
            clear_count++;
         end
         MODE_STEP: begin
            advance_generation();
            step_count++;
         end
         MODE_READ: begin
            if (in_grid)
               s.cell_alive = life_cells[r.cell_y][r.cell_x];
            read_count++;
         end
         default: ;
      endcase
      s.population = life_population;
      s.generation = life_generation;
      s.stable     = life_stable;
      return s;
   endfunction

   function automatic int clamp_coord(int v);
      if (v < 0)
         return 0;
      if (v > GRID_W - 1)
         return GRID_W - 1;
      return v;
   endfunction

   task automatic queue_request(logic [MODE_W-1:0] mode, int x, int y);
      life_request_type r;
      r.mode   = mode;
      r.cell_x = x[COORD_W-1:0];
      r.cell_y = y[COORD_W-1:0];
      pending_requests = {pending_requests, r};
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: a new transaction is offered once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_status = {expected_status, apply_request(offered)};
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() > 0 &&
                ((sent_count >= QUIET_FIRST && sent_count <= QUIET_LAST) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               next_item = pending_requests.pop_front();
               offered   = next_item;
               sent_count++;
               req_bus.valid  <= 1'b1;
               req_bus.mode   <= next_item.mode;
               req_bus.cell_x <= next_item.cell_x;
               req_bus.cell_y <= next_item.cell_y;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_status.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("response with nothing expected: alive=%0b pop=%0d gen=%0d",
                           rsp_bus.cell_alive, rsp_bus.population, rsp_bus.generation);
            end else begin
               want = expected_status.pop_front();
               checked_count++;
               if (rsp_bus.cell_alive !== want.cell_alive ||
                   rsp_bus.population !== want.population ||
                   rsp_bus.generation !== want.generation ||
                   rsp_bus.stable !== want.stable) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("response %0d: expected alive=%0b pop=%0d gen=%0d stable=%0b",
                              checked_count, want.cell_alive, want.population,
                              want.generation, want.stable);
                     $display("   got alive=%0b pop=%0d gen=%0d stable=%0b",
                              rsp_bus.cell_alive, rsp_bus.population,
                              rsp_bus.generation, rsp_bus.stable);
                  end
               end
               if (checked_count == HOLD_AT && !hold_done) begin
                  hold_left = HOLD_CYCLES;
                  hold_done = 1'b1;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (checked_count >= QUIET_FIRST && checked_count <= QUIET_LAST) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Cycles since the last transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      int ox;
      int oy;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.mode   = '0;
      req_bus.cell_x = '0;
      req_bus.cell_y = '0;
      rsp_bus.ready  = 1'b0;
      quiet_cycles   = 0;
      hold_left      = 0;
      hold_done      = 1'b0;
      clear_cells();
      foreach (next_cells[y, x])
         next_cells[y][x] = 1'b0;
      life_population = '0;
      life_generation = '0;
      life_stable     = 1'b0;

      // An empty grid is already stable.
      queue_request(MODE_STEP, 0, 0);
      queue_request(MODE_READ, 0, 0);
      // Blinker along the top edge; the row above the grid counts as dead.
      queue_request(MODE_SET_ALIVE, 0, 0);
      queue_request(MODE_SET_ALIVE, 1, 0);
      queue_request(MODE_SET_ALIVE, 2, 0);
      queue_request(MODE_SET_ALIVE, 63, 63);
      queue_request(MODE_READ, 63, 63);
      queue_request(MODE_SET_DEAD, 63, 63);
      queue_request(MODE_READ, 63, 63);
      queue_request(MODE_SPARE_5, 63, 0);
      queue_request(MODE_SPARE_6, 0, 63);
      queue_request(MODE_SPARE_7, 63, 63);
      queue_request(MODE_STEP, 63, 63);
      queue_request(MODE_READ, 1, 1);
      queue_request(MODE_READ, 0, 0);
      queue_request(MODE_STEP, 0, 0);
      // The grid is already empty here, so this step leaves the generation alone.
      queue_request(MODE_STEP, 0, 0);
      // A block in the far corner is a still life.
      queue_request(MODE_SET_ALIVE, 62, 62);
      queue_request(MODE_SET_ALIVE, 63, 62);
      queue_request(MODE_SET_ALIVE, 62, 63);
      queue_request(MODE_SET_ALIVE, 63, 63);
      queue_request(MODE_STEP, 0, 0);
      queue_request(MODE_READ, 63, 63);
      queue_request(MODE_CLEAR, 63, 63);
      queue_request(MODE_READ, 63, 63);

      // Random patterns in small windows, often against the grid edges, followed
      // by steps and reads around the window, with some stray requests mixed in.
      while (pending_requests.size() < ITEM_TOTAL) begin
         if ($urandom_range(0, 99) < 15)
            queue_request(MODE_CLEAR, $urandom, $urandom);
         case ($urandom_range(0, 3))
            0: ox = 0;
            1: ox = GRID_W - 4;
            default: ox = $urandom_range(0, GRID_W - 4);
         endcase
         case ($urandom_range(0, 3))
            0: oy = 0;
            1: oy = GRID_H - 4;
            default: oy = $urandom_range(0, GRID_H - 4);
         endcase
         repeat ($urandom_range(3, 8))
            queue_request(($urandom_range(0, 4) == 0) ? MODE_SET_DEAD : MODE_SET_ALIVE,
                          ox + $urandom_range(0, 3), oy + $urandom_range(0, 3));
         repeat ($urandom_range(1, 2)) begin
            queue_request(MODE_STEP, $urandom, $urandom);
            repeat ($urandom_range(1, 3))
               queue_request(MODE_READ, clamp_coord(ox - 1 + $urandom_range(0, 5)),
                             clamp_coord(oy - 1 + $urandom_range(0, 5)));
         end
         if ($urandom_range(0, 99) < 30)
            queue_request(MODE_W'($urandom_range(0, 7)), $urandom, $urandom);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || accepted_count < sent_count ||
             expected_status.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d generation steps (%0d of them stable),",
               accepted_count, step_count, stable_step_count);
      $display("%0d reads, %0d clears; checked %0d responses, peak population %0d.",
               read_count, clear_count, checked_count, peak_population);
      if (mismatch_count == 0 && expected_status.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
